// File: hdl/ipuw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuw_pkg
// Shared types and constants for the integer pixel upscale writer.
// ----------------------------------------------------------------------------
package ipuw_pkg;

  // Field widths
  localparam int PIX_IN_W   = 32;
  localparam int PIX_OUT_W  = 24;
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 24;
  localparam int IMG_DIM_W  = 11;
  localparam int BLOW_W     = 4;
  localparam int SCR_DIM_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Parameter defaults
  localparam int DEF_MAX_BLOW       = 8;
  localparam int DEF_MAX_IMAGE_DIM  = 1024;
  localparam int DEF_MAX_SCREEN_DIM = 4096;

  // Register reset values
  localparam logic [IMG_DIM_W-1:0] RST_IMAGE_WIDTH   = IMG_DIM_W'(256);
  localparam logic [IMG_DIM_W-1:0] RST_IMAGE_HEIGHT  = IMG_DIM_W'(256);
  localparam logic [BLOW_W-1:0]    RST_BLOW_FACTOR   = BLOW_W'(2);
  localparam logic [SCR_DIM_W-1:0] RST_SCREEN_WIDTH  = SCR_DIM_W'(640);
  localparam logic [SCR_DIM_W-1:0] RST_SCREEN_HEIGHT = SCR_DIM_W'(480);

  // x / 3 == (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2^16
  localparam int              RECIP3_W     = 16;
  localparam logic [RECIP3_W-1:0] RECIP3   = 16'hAAAB;
  localparam int              RECIP3_SHIFT = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_BLOW_FACTOR   = 3'd2,
    REG_SCREEN_WIDTH  = 3'd3,
    REG_SCREEN_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_OFS,
    ST_DIV,
    ST_BASE,
    ST_ADDR,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;   // capture input transaction
    logic mul;    // scaled sizes and box products
    logic offs;   // screen offsets
    logic div;    // horizontal offset divide, box top
    logic base;   // box left, top row product
    logic start;  // first address, clear box counters
    logic step;   // advance to next write
  } ipuw_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last;
  } ipuw_sts_t;

endpackage

// File: hdl/ipuw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuw_ctrl
// Sequencer: walks one pixel through setup steps, then issues box writes.
// ----------------------------------------------------------------------------
module ipuw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ipuw_pkg::ipuw_cmd_t cmd,
  input  ipuw_pkg::ipuw_sts_t sts
);

  ipuw_pkg::ctrl_state_t state;
  ipuw_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipuw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ipuw_pkg::ST_IDLE: begin
        if (in_valid) state_next = ipuw_pkg::ST_MUL;
      end
      ipuw_pkg::ST_MUL: begin
        // pixel outside the image produces no writes
        state_next = sts.in_range ? ipuw_pkg::ST_OFS : ipuw_pkg::ST_IDLE;
      end
      ipuw_pkg::ST_OFS:  state_next = ipuw_pkg::ST_DIV;
      ipuw_pkg::ST_DIV:  state_next = ipuw_pkg::ST_BASE;
      ipuw_pkg::ST_BASE: state_next = ipuw_pkg::ST_ADDR;
      ipuw_pkg::ST_ADDR: state_next = ipuw_pkg::ST_EMIT;
      ipuw_pkg::ST_EMIT: begin
        if (!out_stall && sts.last) state_next = ipuw_pkg::ST_IDLE;
      end
      default: state_next = ipuw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ipuw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ipuw_pkg::ST_MUL:  cmd.mul   = 1'b1;
      ipuw_pkg::ST_OFS:  cmd.offs  = 1'b1;
      ipuw_pkg::ST_DIV:  cmd.div   = 1'b1;
      ipuw_pkg::ST_BASE: cmd.base  = 1'b1;
      ipuw_pkg::ST_ADDR: cmd.start = 1'b1;
      ipuw_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = !out_stall;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/ipuw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuw_dp
// Datapath: config registers, box placement arithmetic and write address walk.
// ----------------------------------------------------------------------------
module ipuw_dp #(
  parameter int MAX_BLOW       = ipuw_pkg::DEF_MAX_BLOW,
  parameter int MAX_IMAGE_DIM  = ipuw_pkg::DEF_MAX_IMAGE_DIM,
  parameter int MAX_SCREEN_DIM = ipuw_pkg::DEF_MAX_SCREEN_DIM
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr,
  input  logic [ipuw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipuw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [ipuw_pkg::PIX_IN_W-1:0]      pixel_in,
  input  logic [ipuw_pkg::COORD_W-1:0]       src_col,
  input  logic [ipuw_pkg::COORD_W-1:0]       src_row,
  input  ipuw_pkg::ipuw_cmd_t                cmd,
  output ipuw_pkg::ipuw_sts_t                sts,
  output logic [ipuw_pkg::ADDR_W-1:0]        write_address,
  output logic [ipuw_pkg::PIX_OUT_W-1:0]     pixel_out,
  output logic                               last_write
);

  localparam int IW_W   = ipuw_pkg::IMG_DIM_W;
  localparam int BW_W   = ipuw_pkg::BLOW_W;
  localparam int SW_W   = ipuw_pkg::SCR_DIM_W;
  localparam int BOX_W  = (MAX_BLOW > 1) ? $clog2(MAX_BLOW) : 1;
  localparam int NW_W   = IW_W + BW_W;
  localparam int XN_W   = SW_W + 1;
  localparam int XP_W   = XN_W + ipuw_pkg::RECIP3_W;
  localparam int XO_W   = XP_W - ipuw_pkg::RECIP3_SHIFT;
  localparam int YO_W   = SW_W - 1;
  localparam int TOP_W  = NW_W + 1;
  localparam int LEFT_W = NW_W + 1;
  localparam int PR_W   = TOP_W + SW_W;
  localparam int AW     = ipuw_pkg::ADDR_W;

  // Config registers
  logic [IW_W-1:0] image_width;
  logic [IW_W-1:0] image_height;
  logic [BW_W-1:0] blow_factor;
  logic [SW_W-1:0] screen_width;
  logic [SW_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= ipuw_pkg::RST_IMAGE_WIDTH;
      image_height  <= ipuw_pkg::RST_IMAGE_HEIGHT;
      blow_factor   <= ipuw_pkg::RST_BLOW_FACTOR;
      screen_width  <= ipuw_pkg::RST_SCREEN_WIDTH;
      screen_height <= ipuw_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_wr) begin
      case (ipuw_pkg::cfg_reg_t'(cfg_index))
        ipuw_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[IW_W-1:0];
        ipuw_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[IW_W-1:0];
        ipuw_pkg::REG_BLOW_FACTOR:   blow_factor   <= cfg_data[BW_W-1:0];
        ipuw_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[SW_W-1:0];
        ipuw_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[SW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective values: zero acts as one, saturate at the maximum
  logic [IW_W-1:0]  iw;
  logic [IW_W-1:0]  ih;
  logic [BW_W-1:0]  bf;
  logic [SW_W-1:0]  sw;
  logic [SW_W-1:0]  sh;
  logic [BOX_W-1:0] b_last;

  always_comb begin
    iw = (image_width == '0) ? IW_W'(1) :
         ((32'(image_width) > 32'(MAX_IMAGE_DIM)) ? IW_W'(MAX_IMAGE_DIM) : image_width);
    ih = (image_height == '0) ? IW_W'(1) :
         ((32'(image_height) > 32'(MAX_IMAGE_DIM)) ? IW_W'(MAX_IMAGE_DIM) : image_height);
    bf = (blow_factor == '0) ? BW_W'(1) :
         ((32'(blow_factor) > 32'(MAX_BLOW)) ? BW_W'(MAX_BLOW) : blow_factor);
    sw = (screen_width == '0) ? SW_W'(1) :
         ((32'(screen_width) > 32'(MAX_SCREEN_DIM)) ? SW_W'(MAX_SCREEN_DIM) : screen_width);
    sh = (screen_height == '0) ? SW_W'(1) :
         ((32'(screen_height) > 32'(MAX_SCREEN_DIM)) ? SW_W'(MAX_SCREEN_DIM) : screen_height);
    b_last = BOX_W'(bf - BW_W'(1));
  end

  // Captured transaction
  logic [ipuw_pkg::PIX_OUT_W-1:0] pix_swap;
  logic [ipuw_pkg::COORD_W-1:0]   col;
  logic [ipuw_pkg::COORD_W-1:0]   row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_swap <= {pixel_in[7:0], pixel_in[15:8], pixel_in[23:16]};
      col      <= src_col;
      row      <= src_row;
    end
  end

  assign sts.in_range = (IW_W'(col) < iw) && (IW_W'(row) < ih);

  // Setup pipeline, one step per command
  logic [NW_W-1:0]   nw;
  logic [NW_W-1:0]   nh;
  logic [NW_W-1:0]   vrow;
  logic [NW_W-1:0]   hcol;
  logic [XN_W-1:0]   xnum;
  logic [YO_W-1:0]   yoff;
  logic [XP_W-1:0]   xprod;
  logic [TOP_W-1:0]  top;
  logic [PR_W-1:0]   top_prod;
  logic [LEFT_W-1:0] left;
  logic [IW_W-1:0]   flip_row;
  logic [SW_W-1:0]   sw_gap;
  logic [SW_W-1:0]   sh_gap;

  always_comb begin
    flip_row = ih - IW_W'(1) - IW_W'(row);
    sw_gap   = SW_W'(NW_W'(sw) - nw);
    sh_gap   = SW_W'(NW_W'(sh) - nh);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      nw   <= NW_W'(iw) * NW_W'(bf);
      nh   <= NW_W'(ih) * NW_W'(bf);
      vrow <= NW_W'(flip_row) * NW_W'(bf);
      hcol <= NW_W'(col) * NW_W'(bf);
    end
    if (cmd.offs) begin
      xnum <= (NW_W'(sw) > nw) ? {sw_gap, 1'b0} : '0;
      yoff <= (NW_W'(sh) > nh) ? sh_gap[SW_W-1:1] : '0;
    end
    if (cmd.div) begin
      xprod <= XP_W'(xnum) * XP_W'(ipuw_pkg::RECIP3);
      top   <= TOP_W'(yoff) + TOP_W'(vrow);
    end
    if (cmd.base) begin
      left     <= LEFT_W'(xprod[XP_W-1:ipuw_pkg::RECIP3_SHIFT]) + LEFT_W'(hcol);
      top_prod <= PR_W'(top) * PR_W'(sw);
    end
  end

  // Write walk: row base steps by the screen pitch
  logic [AW-1:0]    row_base;
  logic [AW-1:0]    addr;
  logic [BOX_W-1:0] box_col;
  logic [BOX_W-1:0] box_row;
  logic [AW-1:0]    next_row_base;
  logic             row_end;

  assign row_end       = (box_col == b_last);
  assign next_row_base = row_base + AW'(sw);
  assign sts.last      = row_end && (box_row == b_last);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_base <= top_prod[AW-1:0] + AW'(left);
      addr     <= top_prod[AW-1:0] + AW'(left);
    end else if (cmd.step && !sts.last) begin
      if (row_end) begin
        row_base <= next_row_base;
        addr     <= next_row_base;
      end else begin
        addr <= addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_col <= '0;
      box_row <= '0;
    end else if (cmd.start || (cmd.step && sts.last)) begin
      box_col <= '0;
      box_row <= '0;
    end else if (cmd.step) begin
      if (row_end) begin
        box_col <= '0;
        box_row <= box_row + BOX_W'(1);
      end else begin
        box_col <= box_col + BOX_W'(1);
      end
    end
  end

  assign write_address = addr;
  assign pixel_out     = pix_swap;
  assign last_write    = sts.last;

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    box_col <= b_last)
    else $error("box column past blow factor");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    box_row <= b_last)
    else $error("box row past blow factor");

  a_addr_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !row_end) |=> (addr == $past(addr) + AW'(1)))
    else $error("address did not advance within box row");

  a_box_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.last) |=> (box_col == '0 && box_row == '0))
    else $error("box counters not cleared after last write");

endmodule

// File: hdl/integer_pixel_upscale_writer_core.sv
`timescale 1ns / 1ps
// The first write is offered after the setup steps: multiply, offsets,
//   divide, base and first address. A new pixel is taken only when idle;
//   the box walk issues one write per cycle while out_stall is low.
// A pixel outside the image produces no writes; it returns to idle after the multiply step.
// Reset (rst, synchronous): sequencer idle, box counters cleared, config
//   registers return to 256 x 256 image, factor 2, 640 x 480 screen.
// ----------------------------------------------------------------------------
// integer_pixel_upscale_writer_core
// Nearest-neighbor integer upscaler: one source pixel in, one box of
// framebuffer writes out.
// ----------------------------------------------------------------------------
module integer_pixel_upscale_writer_core #(
  parameter int MAX_BLOW       = ipuw_pkg::DEF_MAX_BLOW,
  parameter int MAX_IMAGE_DIM  = ipuw_pkg::DEF_MAX_IMAGE_DIM,
  parameter int MAX_SCREEN_DIM = ipuw_pkg::DEF_MAX_SCREEN_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipuw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipuw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ipuw_pkg::PIX_IN_W-1:0]   pixel_in,
  input  logic [ipuw_pkg::COORD_W-1:0]    src_col,
  input  logic [ipuw_pkg::COORD_W-1:0]    src_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ipuw_pkg::ADDR_W-1:0]     write_address,
  output logic [ipuw_pkg::PIX_OUT_W-1:0]  pixel_out,
  output logic                            last_write
);

  ipuw_pkg::ipuw_cmd_t cmd;
  ipuw_pkg::ipuw_sts_t sts;

  assign cfg_ready = 1'b1;

  ipuw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ipuw_dp #(
    .MAX_BLOW       (MAX_BLOW),
    .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
    .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_in      (pixel_in),
    .src_col       (src_col),
    .src_row       (src_row),
    .cmd           (cmd),
    .sts           (sts),
    .write_address (write_address),
    .pixel_out     (pixel_out),
    .last_write    (last_write)
  );

endmodule
